### hdl/rosi_pkg.sv
package rosi_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int FAR_W         = 33;
    localparam int EPS_W         = 17;
    localparam int VEC_W         = 18;
    localparam int POS_W         = 32;
    localparam int DOT_W         = 52;   // three 18x32 products summed
    localparam int E_W           = 35;   // |e| <= 3*2^32
    localparam int NUM_W         = 35;   // e + bound, |e + bound| < 2^34
    localparam int T_W           = 34;   // saturated distance, signed
    localparam int CFG_IDX_W     = 1;
    localparam int S_TDATA_W     = 272;  // 268 field bits padded to whole bytes
    localparam logic [FAR_W-1:0] FAR_LIMIT_RST = 33'd6553600000;
    localparam logic [EPS_W-1:0] EPS_RST       = 17'd66;

    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAR_EPS   = 1'b1;

    localparam int ITEM_W = 6*VEC_W + 5*POS_W + 1;

    typedef struct packed {
        logic signed [VEC_W-1:0] axis_x, axis_y, axis_z;
        logic signed [VEC_W-1:0] ray_x, ray_y, ray_z;
        logic signed [POS_W-1:0] offset_x, offset_y, offset_z;
        logic signed [POS_W-1:0] slab_low, slab_high;
        logic                    last_axis;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } t_back_state;

    // Queue entry handed from the front part to the back part.
    typedef struct packed {
        logic                    last;
        logic signed [E_W-1:0]   e;
        logic signed [POS_W-1:0] f;
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
    } t_job;

endpackage

### hdl/rosi_front.sv
module rosi_front import rosi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_item             i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output t_job              o_job
);
    // stage 1: products
    logic r_v1, r_v2;
    logic signed [2*POS_W-1:0] r_pe[3];
    logic signed [2*VEC_W-1:0] r_pf[3];
    t_item r_it1;
    t_job  r_job;
    logic signed [DOT_W-1:0] n_e_sum, n_f_sum;
    logic adv2, adv1;

    assign adv2 = !r_v2 || i_ready;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_job   = r_job;

    always_comb begin
        n_e_sum = DOT_W'(r_pe[0]) + DOT_W'(r_pe[1]) + DOT_W'(r_pe[2]);
        n_f_sum = DOT_W'(r_pf[0]) + DOT_W'(r_pf[1]) + DOT_W'(r_pf[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
        if (adv1 && i_valid) begin
            r_pe[0] <= (2*POS_W)'(i_item.axis_x) * (2*POS_W)'(i_item.offset_x);
            r_pe[1] <= (2*POS_W)'(i_item.axis_y) * (2*POS_W)'(i_item.offset_y);
            r_pe[2] <= (2*POS_W)'(i_item.axis_z) * (2*POS_W)'(i_item.offset_z);
            r_pf[0] <= (2*VEC_W)'(i_item.axis_x) * (2*VEC_W)'(i_item.ray_x);
            r_pf[1] <= (2*VEC_W)'(i_item.axis_y) * (2*VEC_W)'(i_item.ray_y);
            r_pf[2] <= (2*VEC_W)'(i_item.axis_z) * (2*VEC_W)'(i_item.ray_z);
            r_it1   <= i_item;
        end
        if (adv2 && r_v1) begin
            // arithmetic shift = floor
            r_job.e    <= E_W'(n_e_sum >>> FRACTION_BITS);
            r_job.f    <= POS_W'(n_f_sum >>> FRACTION_BITS);
            r_job.lo   <= r_it1.slab_low;
            r_job.hi   <= r_it1.slab_high;
            r_job.last <= r_it1.last_axis;
        end
    end
endmodule

### hdl/rosi_queue.sv
module rosi_queue import rosi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    t_job r_mem[2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= !r_wp;
            if (o_valid && i_ready) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
        if (i_valid && o_ready) r_mem[r_wp] <= i_job;
    end
endmodule

### hdl/rosi_div.sv
module rosi_div import rosi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [POS_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [T_W-1:0]   o_quo
);
    // restoring divider, one quotient bit per cycle, on magnitudes
    localparam int NW = NUM_W + FRACTION_BITS;   // scaled dividend
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0]    r_q;
    logic [POS_W:0]   r_rem;
    logic [POS_W-1:0] r_d;
    logic             r_neg, r_busy;
    logic [CW-1:0]    r_cnt;
    logic [POS_W+1:0] n_trial;
    logic [NUM_W-1:0] n_anum;
    logic [NW:0]      n_sq;
    logic signed [NW+1:0] n_val;

    always_comb begin
        n_anum  = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        n_trial = {r_rem, r_q[NW-1]} - {2'b00, r_d};
        n_sq    = r_neg ? (NW+1)'(-{1'b0, r_q}) : {1'b0, r_q};
        n_val   = $signed({n_sq[NW], n_sq});
        if (n_val > (NW+2)'(signed'({1'b0, {(T_W-1){1'b1}}})))
            o_quo = {1'b0, {(T_W-1){1'b1}}};
        else if (n_val < -(NW+2)'(signed'({1'b0, {(T_W-1){1'b1}}})) - 1)
            o_quo = {1'b1, {(T_W-1){1'b0}}};
        else
            o_quo = T_W'(n_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= {n_anum, {FRACTION_BITS{1'b0}}};
            r_rem <= '0;
            r_d   <= i_den[POS_W-1] ? POS_W'(-i_den) : POS_W'(i_den);
            r_neg <= i_num[NUM_W-1] ^ i_den[POS_W-1];
        end else if (r_busy) begin
            if (!n_trial[POS_W+1]) begin
                r_rem <= n_trial[POS_W:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[POS_W-1:0], r_q[NW-1]};
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end
endmodule

### hdl/rosi_back.sv
module rosi_back import rosi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_job             i_job,
    input  logic             i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FAR_W-1:0] i_cfg_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_hit,
    output logic [FAR_W-1:0] o_distance
);
    t_back_state r_st, n_st;
    t_job r_job;
    logic [FAR_W-1:0] r_far_limit;
    logic [EPS_W-1:0] r_eps;
    logic signed [T_W-1:0] r_near, r_far, r_t1;
    logic r_missed, r_started, r_second;
    logic r_ov, r_ohit;
    logic [FAR_W-1:0] r_odist;
    logic div_start, div_done;
    logic signed [T_W-1:0] div_q;
    logic signed [NUM_W-1:0] n_num;
    logic [POS_W:0] n_af;
    logic n_par, take;
    logic signed [T_W-1:0] n_tlo, n_thi, n_near, n_far;

    rosi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(n_num), .i_den(r_job.f), .o_done(div_done), .o_quo(div_q)
    );

    assign o_valid    = r_ov;
    assign o_hit      = r_ohit;
    assign o_distance = r_odist;
    assign o_ready    = (r_st == ST_IDLE);
    assign take       = i_valid && o_ready;

    always_comb begin
        n_af  = r_job.f[POS_W-1] ? (POS_W+1)'(-r_job.f) : (POS_W+1)'(r_job.f);
        n_par = n_af <= (POS_W+1)'(r_eps);
        // low bound starts from ST_UPD, high bound when the first quotient is done
        n_num = NUM_W'(r_job.e) + NUM_W'((r_st == ST_DIV) ? r_job.hi : r_job.lo);
        n_tlo = (r_t1 > div_q) ? div_q : r_t1;
        n_thi = (r_t1 > div_q) ? r_t1 : div_q;
        n_far  = (n_thi < r_far) ? n_thi : r_far;
        n_near = (n_tlo > r_near) ? n_tlo : r_near;
    end

    always_comb begin
        n_st = r_st;
        div_start = 1'b0;
        unique case (r_st)
            ST_IDLE: if (take) n_st = ST_UPD;
            ST_UPD: begin
                if (r_missed || n_par) n_st = ST_OUT;
                else begin
                    div_start = 1'b1;
                    n_st = ST_DIV;
                end
            end
            ST_DIV: if (div_done) begin
                if (!r_second) div_start = 1'b1;
                else n_st = ST_OUT;
            end
            ST_OUT: if (!r_job.last || !r_ov || i_ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_far_limit <= FAR_LIMIT_RST;
            r_eps <= EPS_RST;
            r_near <= '0;
            r_far <= T_W'(FAR_LIMIT_RST);
            r_missed <= 1'b0;
            r_started <= 1'b0;
            r_second <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (i_cfg_wr) begin
                unique case (i_cfg_idx)
                    REG_FAR_LIMIT: begin
                        r_far_limit <= i_cfg_data;
                        if (!r_started) r_far <= T_W'(i_cfg_data);
                    end
                    REG_PAR_EPS: r_eps <= EPS_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (take) begin
                r_job <= i_job;
                r_started <= 1'b1;
                r_second <= 1'b0;
            end
            if (r_st == ST_UPD && !r_missed && n_par &&
                (r_job.lo > r_job.e || r_job.hi < r_job.e))
                r_missed <= 1'b1;
            if (r_st == ST_DIV && div_done) begin
                if (!r_second) begin
                    r_t1 <= div_q;
                    r_second <= 1'b1;
                end else begin
                    r_far  <= n_far;
                    r_near <= n_near;
                    if (n_far < n_near) r_missed <= 1'b1;
                end
            end
            if (r_st == ST_OUT && r_job.last && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
                r_ohit <= !r_missed;
                r_odist <= r_missed ? '0 : FAR_W'(r_near);
                r_near <= '0;
                r_far <= T_W'(r_far_limit);
                r_missed <= 1'b0;
                r_started <= 1'b0;
            end
        end
    end
endmodule

### hdl/ray_obb_slab_intersect_unit.sv
// Channel | Direction | Handshake               | Payload
// s_axis  | in        | s_axis_tvalid/tready    | tdata: box axis item, tlast: last_axis
// m_axis  | out       | m_axis_tvalid/tready    | tdata: distance, tuser: hit
// cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Front: 2-stage dot-product pipe (multiply, then sum and floor shift).
// Back: parallel/slab test, or two serial divisions of NUM_W+FRACTION_BITS
// quotient bits each on one shared restoring divider for a non-parallel
// axis; a parallel or already-missed axis skips the divisions.
// A 2-entry queue parts front and back; the result register frees the back
// as soon as the result is loaded. Reset is synchronous, active low.
module ray_obb_slab_intersect_unit import rosi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // axis_x,y,z, ray_x,y,z, offset_x,y,z, slab_low, slab_high (LSB first), zero padding
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // distance (bits 32:0), zero padding
    output logic [39:0]           m_axis_tdata,
    // hit
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [FAR_W-1:0]      i_cfg_data
);
    t_item item;
    t_job  f_job, q_job;
    logic  f_v, f_r, q_v, q_r;
    logic [FAR_W-1:0] out_dist;

    assign item.axis_x    = s_axis_tdata[17:0];
    assign item.axis_y    = s_axis_tdata[35:18];
    assign item.axis_z    = s_axis_tdata[53:36];
    assign item.ray_x     = s_axis_tdata[71:54];
    assign item.ray_y     = s_axis_tdata[89:72];
    assign item.ray_z     = s_axis_tdata[107:90];
    assign item.offset_x  = s_axis_tdata[139:108];
    assign item.offset_y  = s_axis_tdata[171:140];
    assign item.offset_z  = s_axis_tdata[203:172];
    assign item.slab_low  = s_axis_tdata[235:204];
    assign item.slab_high = s_axis_tdata[267:236];
    assign item.last_axis = s_axis_tlast;
    assign o_cfg_ready    = 1'b1;
    assign m_axis_tdata   = {7'd0, out_dist};

    rosi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_item(item),
        .o_valid(f_v), .i_ready(f_r), .o_job(f_job)
    );

    rosi_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_v), .o_ready(f_r),
        .i_job(f_job), .o_valid(q_v), .i_ready(q_r), .o_job(q_job)
    );

    rosi_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_v), .o_ready(q_r),
        .i_job(q_job), .i_cfg_wr(i_cfg_valid), .i_cfg_idx(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_hit(m_axis_tuser), .o_distance(out_dist)
    );
endmodule

### hdl/rosi_checker.sv
module rosi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 40'd0)
        else $error("miss with nonzero distance");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("padding bits set");
endmodule

bind ray_obb_slab_intersect_unit rosi_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
